>>> design/fsnc_pkg.sv
// Package for the float stream numerics checker: fp32 constants, format and
// register codes, and the element widening and ordering functions.
// No dependencies.
`default_nettype none
package fsnc_pkg;

  localparam logic [31:0] FP32_POS_INF = 32'h7F80_0000;
  localparam logic [31:0] FP32_NEG_INF = 32'hFF80_0000;
  localparam logic [31:0] FP32_QNAN    = 32'h7FC0_0000;
  localparam logic [31:0] FP32_ZERO    = 32'h0000_0000;

  typedef enum logic [1:0] {
    FMT_FP32 = 2'd0,
    FMT_FP16 = 2'd1,
    FMT_BF16 = 2'd2,
    FMT_RSVD = 2'd3
  } fmt_t;

  localparam logic REG_FORMAT = 1'b0;
  localparam logic REG_STATS  = 1'b1;

  function automatic logic is_nan(input logic [31:0] b);
    is_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  endfunction

  // Exact widening of an fp16 value to fp32.
  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic [4:0]  e;
    logic [9:0]  m;
    logic [3:0]  p;
    logic [9:0]  mn;
    logic [30:0] body;
    e = h[14:10];
    m = h[9:0];
    p = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) p = 4'(i);
    end
    mn = m << (4'd10 - p);
    if (e == 5'h1F) begin
      body = {8'hFF, m, 13'd0};
    end else if (e != 5'd0) begin
      body = {8'(e) + 8'd112, m, 13'd0};
    end else if (m == 10'd0) begin
      body = 31'd0;
    end else begin
      body = {8'd103 + 8'(p), mn, 13'd0};
    end
    widen_half = {h[15], body};
  endfunction

  function automatic logic [31:0] widen(input fmt_t f, input logic [31:0] raw);
    case (f)
      FMT_FP16: widen = widen_half(raw[15:0]);
      FMT_BF16: widen = {raw[15:0], 16'd0};
      default:  widen = raw;
    endcase
  endfunction

  // Strict less-than on two non-NaN fp32 values; zeros of both signs are equal.
  function automatic logic fp_lt(input logic [31:0] a, input logic [31:0] b);
    if (a[30:0] == 31'd0 && b[30:0] == 31'd0) begin
      fp_lt = 1'b0;
    end else if (a[31] != b[31]) begin
      fp_lt = a[31];
    end else if (!a[31]) begin
      fp_lt = a[30:0] < b[30:0];
    end else begin
      fp_lt = a[30:0] > b[30:0];
    end
  endfunction

endpackage
`default_nettype wire

>>> design/fsnc_fp_add.sv
// Combinational fp32 adder, round to nearest even, subnormals kept,
// every NaN result given as the canonical quiet NaN. Uses fsnc_pkg.
`default_nettype none
module fsnc_fp_add (
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [31:0] sum
);

  logic        swap;
  logic [31:0] x, y;
  logic [7:0]  ex, ey, d;
  logic [23:0] mx, my;
  logic [26:0] big, small_full, small_sh, small_al;
  logic        sticky, same;
  logic [27:0] s;
  logic [4:0]  lz;
  logic [7:0]  limit, shift;
  logic [26:0] n;
  logic [8:0]  e9;
  logic        up;
  logic [7:0]  field;
  logic [30:0] body;

  always_comb begin
    swap = b[30:0] > a[30:0];
    x = swap ? b : a;
    y = swap ? a : b;
    ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    mx = {x[30:23] != 8'd0, x[22:0]};
    my = {y[30:23] != 8'd0, y[22:0]};
    d = ex - ey;
    big = {mx, 3'b000};
    small_full = {my, 3'b000};
    if (d >= 8'd27) begin
      small_sh = 27'd0;
      sticky = my != 24'd0;
    end else begin
      small_sh = small_full >> d[4:0];
      sticky = (small_full & ~(27'h7FF_FFFF << d[4:0])) != 27'd0;
    end
    small_al = {small_sh[26:1], small_sh[0] | sticky};
    same = x[31] == y[31];
    s = same ? ({1'b0, big} + {1'b0, small_al}) : ({1'b0, big} - {1'b0, small_al});

    lz = 5'd0;
    for (int i = 0; i < 27; i++) begin
      if (s[i]) lz = 5'(26 - i);
    end
    limit = ex - 8'd1;
    shift = ({3'd0, lz} < limit) ? {3'd0, lz} : limit;
    if (s[27]) begin
      n = {s[27:2], s[1] | s[0]};
      e9 = {1'b0, ex} + 9'd1;
    end else begin
      n = s[26:0] << shift[4:0];
      e9 = {1'b0, ex} - {1'b0, shift};
    end
    up = n[2] & (n[1] | n[0] | n[3]);
    field = n[26] ? e9[7:0] : 8'd0;
    body = {field, n[25:3]} + {30'd0, up};

    if (fsnc_pkg::is_nan(a) || fsnc_pkg::is_nan(b)) begin
      sum = fsnc_pkg::FP32_QNAN;
    end else if (x[30:0] == 31'h7F80_0000) begin
      if (y[30:0] == 31'h7F80_0000 && !same) sum = fsnc_pkg::FP32_QNAN;
      else sum = x;
    end else if (s == 28'd0) begin
      sum = {same & x[31], 31'd0};
    end else if (e9 >= 9'd255) begin
      sum = {x[31], 31'h7F80_0000};
    end else begin
      sum = {x[31], body};
    end
  end

endmodule
`default_nettype wire

>>> design/float_stream_numerics_check.sv
// Top level of the float stream numerics checker: APB register file, input
// register, accumulators and result register. Uses fsnc_pkg and fsnc_fp_add.
`default_nettype none
// The block takes one element beat per cycle, sustained, and one result beat
// per tensor. An accepted beat is widened to fp32 into an input register;
// from there it is folded into the running sum and absolute sum (one fp32
// adder each, the loop that sets the clock rate), the running minimum and
// maximum and the sticky zero, NaN and infinity flags. When the beat carries
// is_last, the finished statistics go into the result register, which frees
// the accumulators the same cycle, so a new tensor may start at once. The
// last element's beat passes the input register, then the result register.
// Input is only held back when a result waits in the output register and the
// next last element is ready to leave the input register. Registers: element
// format at byte address 0 (0 fp32, 1 fp16, 2 bf16 in the low 16 bits, 3
// is taken as fp32) and statistics enable at address 4 (reset 1); with it
// clear, sum, absolute sum, minimum and maximum read as zero. Write them
// only while no tensor is in flight.
module float_stream_numerics_check (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] element_bits,
  input  wire logic        is_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [31:0] total_sum,
  output logic      [31:0] total_abs_sum,
  output logic      [31:0] smallest,
  output logic      [31:0] largest,
  output logic             saw_zero,
  output logic             saw_nan,
  output logic             saw_infinity
);

  // Configuration registers.
  fsnc_pkg::fmt_t element_format;
  logic           stats_enable;

  // Input register.
  logic        s1_valid;
  logic        s1_last;
  logic [31:0] s1_x;
  logic        s1_adv;

  // Accumulators.
  logic [31:0] running_sum, running_abs_sum, running_min, running_max;
  logic        zero_seen, nan_seen, inf_seen;
  logic [31:0] sum_next, abs_next, min_next, max_next;
  logic        zero_next, nan_next, inf_next;
  logic [31:0] abs_x;
  logic        x_nan;

  assign pready = 1'b1;

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == fsnc_pkg::REG_FORMAT) prdata = {30'd0, element_format};
    else prdata = {31'd0, stats_enable};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_format <= fsnc_pkg::FMT_FP32;
      stats_enable <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == fsnc_pkg::REG_FORMAT) begin
        element_format <= fsnc_pkg::fmt_t'(pwdata[1:0]);
      end else begin
        stats_enable <= pwdata[0];
      end
    end
  end

  // A beat leaves the input register unless it closes a tensor while the
  // result register is still occupied.
  assign s1_adv = s1_valid && (!s1_last || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_x <= fsnc_pkg::widen(element_format, element_bits);
      s1_last <= is_last;
    end
  end

  assign abs_x = {1'b0, s1_x[30:0]};
  assign x_nan = fsnc_pkg::is_nan(s1_x);

  fsnc_fp_add u_sum_add (
    .a   (running_sum),
    .b   (s1_x),
    .sum (sum_next)
  );

  fsnc_fp_add u_abs_add (
    .a   (running_abs_sum),
    .b   (abs_x),
    .sum (abs_next)
  );

  always_comb begin
    min_next = running_min;
    max_next = running_max;
    if (!x_nan && fsnc_pkg::fp_lt(s1_x, running_min)) min_next = s1_x;
    if (!x_nan && fsnc_pkg::fp_lt(running_max, s1_x)) max_next = s1_x;
    zero_next = zero_seen | (abs_x == 32'd0);
    nan_next = nan_seen | x_nan;
    inf_next = inf_seen | (abs_x == fsnc_pkg::FP32_POS_INF);
  end

  always_ff @(posedge clk) begin
    if (rst || (s1_adv && s1_last)) begin
      running_sum <= fsnc_pkg::FP32_ZERO;
      running_abs_sum <= fsnc_pkg::FP32_ZERO;
      running_min <= fsnc_pkg::FP32_POS_INF;
      running_max <= fsnc_pkg::FP32_NEG_INF;
      zero_seen <= 1'b0;
      nan_seen <= 1'b0;
      inf_seen <= 1'b0;
    end else if (s1_adv) begin
      running_sum <= sum_next;
      running_abs_sum <= abs_next;
      running_min <= min_next;
      running_max <= max_next;
      zero_seen <= zero_next;
      nan_seen <= nan_next;
      inf_seen <= inf_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last) begin
      total_sum <= stats_enable ? sum_next : fsnc_pkg::FP32_ZERO;
      total_abs_sum <= stats_enable ? abs_next : fsnc_pkg::FP32_ZERO;
      smallest <= stats_enable ? min_next : fsnc_pkg::FP32_ZERO;
      largest <= stats_enable ? max_next : fsnc_pkg::FP32_ZERO;
      saw_zero <= zero_next;
      saw_nan <= nan_next;
      saw_infinity <= inf_next;
    end
  end

  // A beat that does not close a tensor never waits in the input register.
  a_mid_beat_moves: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_last |-> s1_adv)
    else $error("non-last beat stalled in input register");

  // Input is only refused while a result waits and another is due.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready && s1_valid && s1_last)
    else $error("input refused without a waiting result");

  // The held minimum and maximum are never NaN.
  a_minmax_not_nan: assert property (@(posedge clk) disable iff (rst)
    !fsnc_pkg::is_nan(running_min) && !fsnc_pkg::is_nan(running_max))
    else $error("NaN reached the running minimum or maximum");

  // Closing a tensor clears the sticky flags.
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_last |=> !zero_seen && !nan_seen && !inf_seen)
    else $error("flags not cleared after last element");

endmodule
`default_nettype wire
